// ===== hw/rtl/oai_pkg.sv =====
// ----------------------------------------------------------------------------
// oai_pkg: shared types and constants for the ordered array block
// Item structs, operation codes and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package oai_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the item channels
  localparam int KIND_W  = 3;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT      = 3'd0,
    KIND_APPEND      = 3'd1,
    KIND_REMOVE      = 3'd2,
    KIND_REMOVE_LAST = 3'd3,
    KIND_READ        = 3'd4,
    KIND_READ_LAST   = 3'd5,
    KIND_CLEAR       = 3'd6
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } cmd_item_t;

  typedef struct packed {
    logic               status;
    logic [WORD_W-1:0]  word_out;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } rsp_item_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic                  insert;
    logic                  remove;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      fill;
    logic [DATA_WIDTH-1:0] word;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/ordered_array_insert_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_array_insert_remove: ordered word array with insert and remove
// The result is registered on the command transfer. Throughput: one
// command per cycle while the response is taken; an insert or remove
// shifts each affected cell in parallel, so the cell chain never stalls
// the input. Reset clears the fill count and the result valid; stored
// words stay undefined until written and are never read before that.
// ----------------------------------------------------------------------------
module ordered_array_insert_remove
  import oai_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      fill_next;
  logic                  accept;
  logic                  ok;
  logic                  do_insert;
  logic                  do_remove;
  logic                  do_read;
  logic [CNT_W-1:0]      ins_pos;
  logic [IDX_W-1:0]      rd_addr;
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      fill_c;
  logic                  full;
  logic                  empty;
  logic [CNT_W-1:0]      fill_dec;
  logic [DATA_WIDTH-1:0] rd_word;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign pos_c    = CMP_W'(cmd.position);
  assign fill_c   = CMP_W'(fill);
  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign fill_dec = fill - CNT_W'(1);

  always_comb begin
    ok        = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_read   = 1'b0;
    ins_pos   = CNT_W'(cmd.position);
    rd_addr   = IDX_W'(cmd.position);
    fill_next = fill;
    case (cmd.kind)
      KIND_INSERT: begin
        ok        = !full && (pos_c <= fill_c);
        do_insert = ok;
        fill_next = ok ? fill + CNT_W'(1) : fill;
      end
      KIND_APPEND: begin
        ok        = !full;
        do_insert = ok;
        ins_pos   = fill;
        fill_next = ok ? fill + CNT_W'(1) : fill;
      end
      KIND_REMOVE: begin
        ok        = (pos_c < fill_c);
        do_remove = ok;
        fill_next = ok ? fill_dec : fill;
      end
      KIND_REMOVE_LAST: begin
        ok        = !empty;
        fill_next = ok ? fill_dec : fill;
      end
      KIND_READ: begin
        ok      = (pos_c < fill_c);
        do_read = ok;
      end
      KIND_READ_LAST: begin
        ok      = !empty;
        do_read = ok;
        rd_addr = IDX_W'(fill_dec);
      end
      KIND_CLEAR: begin
        ok        = 1'b1;
        fill_next = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign ctrl.insert = accept && do_insert;
  assign ctrl.remove = accept && do_remove;
  assign ctrl.pos    = ins_pos;
  assign ctrl.fill   = fill;
  assign ctrl.word   = DATA_WIDTH'(cmd.word_in);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_word;
    logic [DATA_WIDTH-1:0] upper_word;

    if (i == 0) begin : g_first
      assign lower_word = '0;
    end else begin : g_lower
      assign lower_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_word = '0;
    end else begin : g_upper
      assign upper_word = cell_word[i+1];
    end

    oai_cell u_cell (
      .clk        (clk),
      .idx        (CNT_W'(i)),
      .ctrl       (ctrl),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .word       (cell_word[i])
    );
  end

  assign rd_word = cell_word[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status   <= !ok;
      rsp.word_out <= do_read ? WORD_W'(rd_word) : '0;
      rsp.count    <= COUNT_W'(fill_next);
      rsp.is_empty <= (fill_next == '0);
    end
  end

endmodule

// ===== hw/rtl/oai_cell.sv =====
// ----------------------------------------------------------------------------
// oai_cell: one storage slot of the ordered array
// Holds one word; loads the new word, its lower neighbor's word on an insert
// shift, or its upper neighbor's word on a remove shift.
// ----------------------------------------------------------------------------
module oai_cell
  import oai_pkg::*;
(
  input  logic                  clk,
  input  logic [CNT_W-1:0]      idx,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] lower_word,
  input  logic [DATA_WIDTH-1:0] upper_word,
  output logic [DATA_WIDTH-1:0] word
);

  logic [CNT_W:0] idx_plus;

  assign idx_plus = {1'b0, idx} + {{CNT_W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (idx == ctrl.pos) begin
        word <= ctrl.word;
      end else if (idx > ctrl.pos && idx <= ctrl.fill) begin
        word <= lower_word;
      end
    end else if (ctrl.remove) begin
      // slots pos .. fill-2 pull down from above
      if (idx >= ctrl.pos && idx_plus < {1'b0, ctrl.fill}) begin
        word <= upper_word;
      end
    end
  end

endmodule
